@@ rtl/core/ibs_pkg.sv @@
`timescale 1ns / 1ps

package ibs_pkg;

  // primitive codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // pin codes
  localparam logic PIN_SCL = 1'b0;
  localparam logic PIN_SDA = 1'b1;

  localparam int STEP_W = 5;

  // index of the final action of each primitive
  localparam logic [STEP_W-1:0] LAST_START = 5'd3;
  localparam logic [STEP_W-1:0] LAST_STOP  = 5'd2;
  localparam logic [STEP_W-1:0] LAST_WRITE = 5'd26;
  localparam logic [STEP_W-1:0] LAST_READ  = 5'd20;

  // classified primitive passed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        data;       // tx byte for write, slave bits for read
    logic              flag;       // ack received for write, send ack for read
    logic [STEP_W-1:0] last_step;
  } cmd_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

@@ rtl/core/i2c_master_byte_sequencer_core.sv @@
`timescale 1ns / 1ps
// latency: a primitive's word is written into the front queue, then loaded into the back
// sequencer register, and its first pin action goes through the back output register
// throughput: the back sequencer gives one action per cycle unless pop stalls; a primitive has
// 4 (start), 3 (stop), 27 (write) or 21 (read) steps; the two entry queue absorbs input bursts
// reset: synchronous rst empties the command queue, idles the sequencer and empties the output

module i2c_master_byte_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic [7:0] slave_bits,
  input  logic       slave_ack_level,
  output logic       empty,
  input  logic       pop,
  output logic       pin_select,
  output logic       pin_level,
  output logic       wait_after,
  output logic [7:0] read_byte,
  output logic       ack_received,
  output logic       last_action
);

  ibs_pkg::cmd_head_t head;
  logic               take;

  // front: classify and queue primitives
  ibs_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .operation       (operation),
    .tx_byte         (tx_byte),
    .send_ack        (send_ack),
    .slave_bits      (slave_bits),
    .slave_ack_level (slave_ack_level),
    .head            (head),
    .take            (take)
  );

  // back: step through pin actions
  ibs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .pin_select   (pin_select),
    .pin_level    (pin_level),
    .wait_after   (wait_after),
    .read_byte    (read_byte),
    .ack_received (ack_received),
    .last_action  (last_action)
  );

endmodule

@@ rtl/core/ibs_front.sv @@
`timescale 1ns / 1ps

module ibs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic [7:0]         tx_byte,
  input  logic               send_ack,
  input  logic [7:0]         slave_bits,
  input  logic               slave_ack_level,
  output ibs_pkg::cmd_head_t head,
  input  logic               take
);

  ibs_pkg::cmd_t in_cmd;
  ibs_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_take;

  // classify the incoming word
  always_comb begin
    in_cmd.op = operation;
    if (operation == ibs_pkg::OP_READ) begin
      in_cmd.data = slave_bits;
      in_cmd.flag = send_ack;
    end else begin
      in_cmd.data = tx_byte;
      in_cmd.flag = ~slave_ack_level;
    end
    unique case (operation)
      ibs_pkg::OP_START: in_cmd.last_step = ibs_pkg::LAST_START;
      ibs_pkg::OP_STOP:  in_cmd.last_step = ibs_pkg::LAST_STOP;
      ibs_pkg::OP_WRITE: in_cmd.last_step = ibs_pkg::LAST_WRITE;
      default:           in_cmd.last_step = ibs_pkg::LAST_READ;
    endcase
  end

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_take = take && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];

  // two entry command queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule

@@ rtl/core/ibs_back.sv @@
`timescale 1ns / 1ps

module ibs_back (
  input  logic               clk,
  input  logic               rst,
  input  ibs_pkg::cmd_head_t head,
  output logic               take,
  output logic               empty,
  input  logic               pop,
  output logic               pin_select,
  output logic               pin_level,
  output logic               wait_after,
  output logic [7:0]         read_byte,
  output logic               ack_received,
  output logic               last_action
);

  // bit phases of a write
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // fixed steps of the write and read tails
  localparam logic [ibs_pkg::STEP_W-1:0] WR_ACK_STEP  = 5'd24;
  localparam logic [ibs_pkg::STEP_W-1:0] WR_ACK_HIGH  = 5'd25;
  localparam logic [ibs_pkg::STEP_W-1:0] RD_BITS_LAST = 5'd16;
  localparam logic [ibs_pkg::STEP_W-1:0] RD_ACK_STEP  = 5'd17;
  localparam logic [ibs_pkg::STEP_W-1:0] RD_ACK_HIGH  = 5'd18;
  localparam logic [ibs_pkg::STEP_W-1:0] RD_ACK_LOW   = 5'd19;

  ibs_pkg::cmd_t               cur;
  logic                        active;
  logic [ibs_pkg::STEP_W-1:0]  step;
  logic [1:0]                  phase;
  logic [7:0]                  sr;
  logic                        out_valid;
  logic                        advance;
  logic                        is_last;
  logic                        load;
  logic                        act_pin;
  logic                        act_level;
  logic                        act_wait;

  assign is_last = (step == cur.last_step);
  assign advance = active && (!out_valid || pop);
  assign load    = head.valid && (!active || (advance && is_last));
  assign take    = load;
  assign empty   = !out_valid;

  // pin action for the current step
  always_comb begin
    act_pin   = ibs_pkg::PIN_SCL;
    act_level = 1'b0;
    act_wait  = 1'b0;
    unique case (cur.op)
      ibs_pkg::OP_START: begin
        unique case (step[1:0])
          2'd0:    begin act_pin = ibs_pkg::PIN_SCL; act_level = 1'b1; end
          2'd1:    begin act_pin = ibs_pkg::PIN_SDA; act_level = 1'b1; act_wait = 1'b1; end
          2'd2:    begin act_pin = ibs_pkg::PIN_SDA; act_level = 1'b0; end
          default: begin act_pin = ibs_pkg::PIN_SCL; act_level = 1'b0; end
        endcase
      end
      ibs_pkg::OP_STOP: begin
        unique case (step[1:0])
          2'd0:    begin act_pin = ibs_pkg::PIN_SDA; act_level = 1'b0; act_wait = 1'b1; end
          2'd1:    begin act_pin = ibs_pkg::PIN_SCL; act_level = 1'b1; act_wait = 1'b1; end
          default: begin act_pin = ibs_pkg::PIN_SDA; act_level = 1'b1; end
        endcase
      end
      ibs_pkg::OP_WRITE: begin
        if (step < WR_ACK_STEP) begin
          unique case (phase)
            PH_DATA: begin act_pin = ibs_pkg::PIN_SDA; act_level = sr[7]; end
            PH_HIGH: begin act_pin = ibs_pkg::PIN_SCL; act_level = 1'b1; act_wait = 1'b1; end
            default: begin act_pin = ibs_pkg::PIN_SCL; act_level = 1'b0; end
          endcase
        end else if (step == WR_ACK_STEP) begin
          act_pin = ibs_pkg::PIN_SDA; act_level = 1'b1; act_wait = 1'b1;
        end else if (step == WR_ACK_HIGH) begin
          act_pin = ibs_pkg::PIN_SCL; act_level = 1'b1; act_wait = 1'b1;
        end else begin
          act_pin = ibs_pkg::PIN_SCL; act_level = 1'b0;
        end
      end
      default: begin
        if (step == '0) begin
          act_pin = ibs_pkg::PIN_SDA; act_level = 1'b1;
        end else if (step <= RD_BITS_LAST) begin
          // odd steps raise SCL, even steps lower it and wait
          act_pin   = ibs_pkg::PIN_SCL;
          act_level = step[0];
          act_wait  = ~step[0];
        end else if (step == RD_ACK_STEP) begin
          act_pin = ibs_pkg::PIN_SDA; act_level = ~cur.flag;
        end else if (step == RD_ACK_HIGH) begin
          act_pin = ibs_pkg::PIN_SCL; act_level = 1'b1; act_wait = 1'b1;
        end else if (step == RD_ACK_LOW) begin
          act_pin = ibs_pkg::PIN_SCL; act_level = 1'b0;
        end else begin
          act_pin = ibs_pkg::PIN_SDA; act_level = 1'b1;
        end
      end
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (advance && is_last) begin
      active <= 1'b0;
    end
  end

  // sequencer payload: command, step, write phase and shift register
  always_ff @(posedge clk) begin
    if (load) begin
      cur   <= head.cmd;
      step  <= '0;
      phase <= PH_DATA;
      sr    <= head.cmd.data;
    end else if (advance) begin
      step  <= step + 1'b1;
      phase <= (phase == PH_LOW) ? PH_DATA : phase + 2'd1;
      if (cur.op == ibs_pkg::OP_WRITE && phase == PH_LOW) begin
        sr <= {sr[6:0], 1'b0};
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pin_select   <= act_pin;
      pin_level    <= act_level;
      wait_after   <= act_wait;
      last_action  <= is_last;
      read_byte    <= (is_last && cur.op == ibs_pkg::OP_READ) ? cur.data : 8'd0;
      ack_received <= is_last && (cur.op == ibs_pkg::OP_WRITE) && cur.flag;
    end
  end

endmodule

@@ sim/tb_i2c_master_byte_sequencer_core.sv @@
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer_core;

  // one bus primitive as offered on the input side
  typedef struct {
    logic [1:0] op;
    logic [7:0] tx;
    logic       sack;
    logic [7:0] sbits;
    logic       slack;
    bit         drain_first;
  } prim_t;

  // one pin action as seen on the result side
  typedef struct {
    logic       sel;
    logic       lvl;
    logic       wt;
    logic [7:0] rbyte;
    logic       ack;
    logic       last;
  } action_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] operation = ibs_pkg::OP_START;
  logic [7:0] tx_byte = 8'h00;
  logic       send_ack = 1'b0;
  logic [7:0] slave_bits = 8'h00;
  logic       slave_ack_level = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       pin_select;
  logic       pin_level;
  logic       wait_after;
  logic [7:0] read_byte;
  logic       ack_received;
  logic       last_action;

  prim_t   prim_queue[$];
  action_t pin_actions_due[$];
  prim_t   cur_prim;
  int      err_cnt = 0;
  int      prim_total = 0;
  int      accepted_cnt = 0;
  int      gap_cnt = 0;
  bit      send_burst = 1'b0;
  int      pop_wait = 0;
  int      hold_cnt = 0;
  int      got_cnt = 0;
  bit      recv_burst = 1'b0;

  i2c_master_byte_sequencer_core uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .tx_byte(tx_byte),
    .send_ack(send_ack),
    .slave_bits(slave_bits),
    .slave_ack_level(slave_ack_level),
    .empty(empty),
    .pop(pop),
    .pin_select(pin_select),
    .pin_level(pin_level),
    .wait_after(wait_after),
    .read_byte(read_byte),
    .ack_received(ack_received),
    .last_action(last_action)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  function automatic action_t mk_action(logic sel, logic lvl, logic wt);
    action_t a;
    a.sel = sel;
    a.lvl = lvl;
    a.wt = wt;
    a.rbyte = 8'h00;
    a.ack = 1'b0;
    a.last = 1'b0;
    return a;
  endfunction

  // expand one primitive into its ordered pin actions
  function automatic void plan_actions(input prim_t p);
    action_t seq[$];
    action_t a;
    logic [7:0] d;
    logic [7:0] rb;
    logic ak;
    d = 8'h00;
    rb = 8'h00;
    ak = 1'b0;
    case (p.op)
      ibs_pkg::OP_START: begin
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b1, 1'b0));
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b1, 1'b1));
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b0, 1'b0));
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b0, 1'b0));
      end
      ibs_pkg::OP_STOP: begin
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b0, 1'b1));
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b1, 1'b1));
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b1, 1'b0));
      end
      ibs_pkg::OP_WRITE: begin
        d = p.tx;
        for (int i = 0; i < 8; i++) begin
          seq.push_back(mk_action(ibs_pkg::PIN_SDA, d[7], 1'b0));
          seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b1, 1'b1));
          seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b0, 1'b0));
          d = {d[6:0], 1'b0};
        end
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b1, 1'b1));
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b1, 1'b1));
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b0, 1'b0));
        ak = ~p.slack;
      end
      default: begin
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b1, 1'b0));
        for (int i = 0; i < 8; i++) begin
          seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b1, 1'b0));
          d = {d[6:0], p.sbits[7-i]};
          seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b0, 1'b1));
        end
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, ~p.sack, 1'b0));
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b1, 1'b1));
        seq.push_back(mk_action(ibs_pkg::PIN_SCL, 1'b0, 1'b0));
        seq.push_back(mk_action(ibs_pkg::PIN_SDA, 1'b1, 1'b0));
        rb = d;
      end
    endcase
    // final action carries the read byte and the ack flag
    a = seq[seq.size()-1];
    a.rbyte = rb;
    a.ack = ak;
    a.last = 1'b1;
    seq[seq.size()-1] = a;
    foreach (seq[i]) pin_actions_due.push_back(seq[i]);
  endfunction

  // primitive with random content in every field
  function automatic prim_t rand_prim(logic [1:0] op);
    prim_t p;
    p.op = op;
    p.tx = 8'($urandom);
    p.sack = 1'($urandom);
    p.sbits = 8'($urandom);
    p.slack = 1'($urandom);
    p.drain_first = 1'b0;
    return p;
  endfunction

  // one pause in the middle of the run waits for the block to drain
  task automatic add_prim(input prim_t p);
    if (prim_queue.size() == 130) p.drain_first = 1'b1;
    prim_queue.push_back(p);
    prim_total++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // driver: offers primitives from the queue with random gaps
  always @(posedge clk) begin : drv_p
    logic nxt_push;
    if (rst) begin
      push <= 1'b0;
    end else begin
      nxt_push = push;
      if (push && !full) begin
        plan_actions(cur_prim);
        accepted_cnt++;
        nxt_push = 1'b0;
        gap_cnt = send_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
      end
      if (!nxt_push) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (prim_queue.size() > 0 &&
                     !(prim_queue[0].drain_first && pin_actions_due.size() != 0)) begin
          cur_prim = prim_queue.pop_front();
          operation <= cur_prim.op;
          tx_byte <= cur_prim.tx;
          send_ack <= cur_prim.sack;
          slave_bits <= cur_prim.sbits;
          slave_ack_level <= cur_prim.slack;
          nxt_push = 1'b1;
        end
      end
      push <= nxt_push;
    end
  end

  // monitor: pops pin actions with random stalls and checks each word
  always @(posedge clk) begin : mon_p
    action_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pin_actions_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected pin action, actual sel %0b lvl %0b wait %0b", $time,
                   pin_select, pin_level, wait_after);
        end else begin
          want = pin_actions_due.pop_front();
          check_field("pin_select", 8'(want.sel), 8'(pin_select));
          check_field("pin_level", 8'(want.lvl), 8'(pin_level));
          check_field("wait_after", 8'(want.wt), 8'(wait_after));
          check_field("read_byte", want.rbyte, read_byte);
          check_field("ack_received", 8'(want.ack), 8'(ack_received));
          check_field("last_action", 8'(want.last), 8'(last_action));
        end
        got_cnt++;
        pop_wait = recv_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        // long hold-off so the block backs up and stalls its input
        if (got_cnt == 200) hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    prim_t p;
    int n_wr;
    int n_rd;
    // directed: edge bytes, both ack levels, every primitive
    add_prim(rand_prim(ibs_pkg::OP_START));
    p = rand_prim(ibs_pkg::OP_WRITE); p.tx = 8'h00; p.slack = 1'b0; add_prim(p);
    p = rand_prim(ibs_pkg::OP_WRITE); p.tx = 8'hFF; p.slack = 1'b1; add_prim(p);
    p = rand_prim(ibs_pkg::OP_WRITE); p.tx = 8'hA5; p.slack = 1'b0; add_prim(p);
    p = rand_prim(ibs_pkg::OP_WRITE); p.tx = 8'h5A; p.slack = 1'b1; add_prim(p);
    add_prim(rand_prim(ibs_pkg::OP_START));
    p = rand_prim(ibs_pkg::OP_READ); p.sbits = 8'h00; p.sack = 1'b1; add_prim(p);
    p = rand_prim(ibs_pkg::OP_READ); p.sbits = 8'hFF; p.sack = 1'b0; add_prim(p);
    p = rand_prim(ibs_pkg::OP_READ); p.sbits = 8'h5A; p.sack = 1'b1; add_prim(p);
    p = rand_prim(ibs_pkg::OP_READ); p.sbits = 8'hA5; p.sack = 1'b0; add_prim(p);
    add_prim(rand_prim(ibs_pkg::OP_STOP));
    add_prim(rand_prim(ibs_pkg::OP_STOP));
    add_prim(rand_prim(ibs_pkg::OP_START));
    add_prim(rand_prim(ibs_pkg::OP_START));
    add_prim(rand_prim(ibs_pkg::OP_STOP));
    // random: mostly well-formed transactions, some loose primitives
    while (prim_total < 245) begin
      if ($urandom_range(0, 4) != 0) begin
        add_prim(rand_prim(ibs_pkg::OP_START));
        n_wr = $urandom_range(1, 4);
        for (int i = 0; i < n_wr; i++) add_prim(rand_prim(ibs_pkg::OP_WRITE));
        if ($urandom_range(0, 1) == 1) begin
          add_prim(rand_prim(ibs_pkg::OP_START));
          n_rd = $urandom_range(1, 4);
          for (int i = 0; i < n_rd; i++) begin
            p = rand_prim(ibs_pkg::OP_READ);
            p.sack = (i != n_rd - 1);
            add_prim(p);
          end
        end
        add_prim(rand_prim(ibs_pkg::OP_STOP));
      end else begin
        add_prim(rand_prim(2'($urandom)));
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (accepted_cnt != prim_total) @(posedge clk);
    while (pin_actions_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ibs_pkg.sv
rtl/core/ibs_front.sv
rtl/core/ibs_back.sv
rtl/core/i2c_master_byte_sequencer_core.sv
sim/tb_i2c_master_byte_sequencer_core.sv
